### sv/lbua_pkg.sv
`default_nettype none
package lbua_pkg;

   localparam int UNIT_COUNT = 16;
   localparam int UNIT_W     = 4;
   localparam int ID_W       = 32;
   localparam int STAMP_W    = 32;
   localparam int CFG_W      = 5;

   // register map (byte address / 4)
   localparam logic REG_ACTIVE_UNITS = 1'b0;

   localparam logic [CFG_W-1:0] ACTIVE_UNITS_RESET = CFG_W'(UNIT_COUNT);

   typedef struct packed {
      logic [ID_W-1:0]   resource_id;
      logic [UNIT_W-1:0] hint_unit;
   } lbua_req_type;

   typedef struct packed {
      logic [UNIT_W-1:0] assigned_unit;
      logic              was_hit;
   } lbua_rsp_type;

endpackage
`default_nettype wire

### sv/lru_binding_unit_allocator_top.sv
`default_nettype none
// LRU binding-unit allocator. Each request carries a resource id and the unit
// it was last bound to. A 32-bit use counter steps on every request (wrapping).
// If the hinted unit lies in 1..n-1 (n = active_units clamped to 2..16) and
// already holds the id, the request is a hit and that unit's timestamp is
// refreshed. Otherwise the unit in 1..n-1 with the oldest timestamp (lowest
// index on ties) takes the id and the new timestamp. Unit 0 is never handed
// out. Ids and timestamps live in two 16-entry synchronous RAMs (registered
// read); per-entry valid flops make never-written entries read as zero, so
// there is no clearing pass after reset. One request is in flight at a time:
// a hit passes through the check and hit states, a miss through the check,
// scan (skipped when n is 2) and write states; the timestamp RAM read port
// feeds the oldest-entry scan one timestamp per cycle. A finished response
// sits in the output register, so the next request can be taken while it
// waits. active_units sits at byte address 0 of the APB port; write it only
// while the block is idle.
module lru_binding_unit_allocator_top
   import lbua_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   // request channel
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire lbua_req_type       req_data,
   // response channel
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output lbua_rsp_type            rsp_data,
   // APB config port
   input  wire logic               psel,
   input  wire logic               penable,
   input  wire logic               pwrite,
   input  wire logic [2:0]         paddr,
   input  wire logic [31:0]        pwdata,
   output logic [31:0]             prdata,
   output logic                    pready
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,   // id / unit-1 timestamp back from RAM
      ST_SCAN,    // walk timestamps 2..n-1
      ST_WRITE,   // miss: store id and stamp in victim
      ST_HIT      // hit: refresh stamp
   } state_type;

   state_type            state_ff;
   lbua_req_type         req_ff;
   logic [STAMP_W-1:0]   use_counter_ff;
   logic [STAMP_W-1:0]   stamp_ff;
   logic [UNIT_W-1:0]    best_ff;
   logic [STAMP_W-1:0]   best_time_ff;
   logic [UNIT_W-1:0]    cmp_ff;
   logic                 rsp_valid_ff;
   lbua_rsp_type         rsp_data_ff;
   logic [CFG_W-1:0]     active_units_ff;

   // storage
   logic [ID_W-1:0]      id_mem    [UNIT_COUNT];
   logic [STAMP_W-1:0]   time_mem  [UNIT_COUNT];
   logic [UNIT_COUNT-1:0] id_vld_ff;
   logic [UNIT_COUNT-1:0] tm_vld_ff;
   logic [ID_W-1:0]      id_rd_ff;
   logic                 id_rvld_ff;
   logic [STAMP_W-1:0]   tm_rd_ff;
   logic                 tm_rvld_ff;

   logic [UNIT_W-1:0]    id_raddr;
   logic [UNIT_W-1:0]    tm_raddr;
   logic [UNIT_W-1:0]    tm_waddr;
   logic                 id_we;
   logic                 tm_we;
   logic [ID_W-1:0]      id_eff;
   logic [STAMP_W-1:0]   tm_eff;
   logic [CFG_W-1:0]     n_eff;
   logic [UNIT_W-1:0]    last_idx;
   logic                 hit;
   logic                 slot_free;
   logic                 cfg_we;

   // ---------------- config port ----------------
   assign pready = 1'b1;
   assign cfg_we = psel && penable && pwrite && pready && (paddr[2] == REG_ACTIVE_UNITS);

   always_ff @(posedge clock) begin
      if (reset) begin
         active_units_ff <= ACTIVE_UNITS_RESET;
      end else if (cfg_we) begin
         active_units_ff <= pwdata[CFG_W-1:0];
      end
   end

   always_comb begin
      prdata = '0;
      if (paddr[2] == REG_ACTIVE_UNITS) begin
         prdata = {{(32-CFG_W){1'b0}}, active_units_ff};
      end
   end

   // effective unit count, clamped to 2..UNIT_COUNT
   always_comb begin
      n_eff = active_units_ff;
      if (active_units_ff > CFG_W'(UNIT_COUNT)) begin
         n_eff = CFG_W'(UNIT_COUNT);
      end else if (active_units_ff < CFG_W'(2)) begin
         n_eff = CFG_W'(2);
      end
   end

   assign last_idx  = UNIT_W'(n_eff - CFG_W'(1));
   assign id_eff    = id_rvld_ff ? id_rd_ff : '0;
   assign tm_eff    = tm_rvld_ff ? tm_rd_ff : '0;
   assign hit       = (req_ff.hint_unit != '0) &&
                      ({1'b0, req_ff.hint_unit} < n_eff) &&
                      (id_eff == req_ff.resource_id);
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   // ---------------- RAM addressing ----------------
   always_comb begin
      id_raddr = req_ff.hint_unit;
      tm_raddr = UNIT_W'(1);
      unique case (state_ff)
         ST_IDLE:  begin
            id_raddr = req_data.hint_unit;
            tm_raddr = UNIT_W'(1);
         end
         ST_CHECK: tm_raddr = UNIT_W'(2);
         ST_SCAN:  tm_raddr = UNIT_W'(cmp_ff + UNIT_W'(1));
         default:  tm_raddr = UNIT_W'(1);
      endcase
   end

   assign id_we    = (state_ff == ST_WRITE) && slot_free;
   assign tm_we    = ((state_ff == ST_WRITE) || (state_ff == ST_HIT)) && slot_free;
   assign tm_waddr = (state_ff == ST_HIT) ? req_ff.hint_unit : best_ff;

   always_ff @(posedge clock) begin
      if (id_we) begin
         id_mem[best_ff] <= req_ff.resource_id;
      end
      id_rd_ff <= id_mem[id_raddr];
   end

   always_ff @(posedge clock) begin
      if (tm_we) begin
         time_mem[tm_waddr] <= stamp_ff;
      end
      tm_rd_ff <= time_mem[tm_raddr];
   end

   // valid bits: unwritten entries read as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         id_vld_ff  <= '0;
         tm_vld_ff  <= '0;
         id_rvld_ff <= 1'b0;
         tm_rvld_ff <= 1'b0;
      end else begin
         if (id_we) begin
            id_vld_ff[best_ff] <= 1'b1;
         end
         if (tm_we) begin
            tm_vld_ff[tm_waddr] <= 1'b1;
         end
         id_rvld_ff <= id_vld_ff[id_raddr];
         tm_rvld_ff <= tm_vld_ff[tm_raddr];
      end
   end

   // ---------------- control ----------------
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         use_counter_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         // write and hit states load the next response themselves
         if (rsp_valid_ff && !rsp_stall &&
             (state_ff != ST_WRITE) && (state_ff != ST_HIT)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  req_ff         <= req_data;
                  use_counter_ff <= use_counter_ff + STAMP_W'(1);
                  stamp_ff       <= use_counter_ff + STAMP_W'(1);
                  state_ff       <= ST_CHECK;
               end
            end
            ST_CHECK: begin
               best_ff      <= UNIT_W'(1);
               best_time_ff <= tm_eff;
               cmp_ff       <= UNIT_W'(2);
               if (hit) begin
                  state_ff <= ST_HIT;
               end else if (last_idx == UNIT_W'(1)) begin
                  state_ff <= ST_WRITE;
               end else begin
                  state_ff <= ST_SCAN;
               end
            end
            ST_SCAN: begin
               // strict compare keeps the lowest index on ties
               if (tm_eff < best_time_ff) begin
                  best_ff      <= cmp_ff;
                  best_time_ff <= tm_eff;
               end
               if (cmp_ff == last_idx) begin
                  state_ff <= ST_WRITE;
               end else begin
                  cmp_ff <= UNIT_W'(cmp_ff + UNIT_W'(1));
               end
            end
            ST_WRITE: begin
               if (slot_free) begin
                  rsp_valid_ff              <= 1'b1;
                  rsp_data_ff.assigned_unit <= best_ff;
                  rsp_data_ff.was_hit       <= 1'b0;
                  state_ff                  <= ST_IDLE;
               end
            end
            ST_HIT: begin
               if (slot_free) begin
                  rsp_valid_ff              <= 1'b1;
                  rsp_data_ff.assigned_unit <= req_ff.hint_unit;
                  rsp_data_ff.was_hit       <= 1'b1;
                  state_ff                  <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule
`default_nettype wire

### bench/lru_binding_unit_allocator_top_test.sv
`timescale 1ns / 1ps

// Bench for the LRU binding-unit allocator.
// A directed script runs first, with a few expected bindings typed in by hand.
// Random phases follow under varying unit counts and idle patterns.
// Requests not typed in by hand are scored against a local LRU predictor:
// each response is popped in order and compared field by field.
module lru_binding_unit_allocator_top_test;
   import lbua_pkg::*;

   localparam int CLOCK_PERIOD   = 8;
   localparam int WATCHDOG_LIMIT = 3000;  // cycles with no request or response moving
   localparam int HOLD_CYCLES    = 300;   // long response back-pressure
   localparam int SETTLE_CYCLES  = 40;    // one miss scan plus margin
   localparam int PHASE_COUNT    = 10;
   localparam int PHASE_REQUESTS = 130;
   localparam int SCRIPT_LEN     = 24;

   localparam logic [2:0] ACTIVE_UNITS_ADDR = {REG_ACTIVE_UNITS, 2'b00};

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   lbua_req_type        req_data;
   logic                rsp_valid;
   logic                rsp_stall;
   lbua_rsp_type        rsp_data;
   logic                psel;
   logic                penable;
   logic                pwrite;
   logic [2:0]          paddr;
   logic [31:0]         pwdata;
   logic [31:0]         prdata;
   logic                pready;

   lru_binding_unit_allocator_top i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   // ---------------------------------------------------------------------
   // Predictor state: a shadow copy of the unit table, the use counter and
   // the active_units register.
   // ---------------------------------------------------------------------
   logic [ID_W-1:0]    unit_owner [UNIT_COUNT];
   logic [STAMP_W-1:0] unit_stamp [UNIT_COUNT];
   logic [STAMP_W-1:0] use_count;
   logic [CFG_W-1:0]   active_cfg;

   lbua_rsp_type pending_bindings [$];   // expected responses, oldest first
   int errors;

   // idle pattern, set per phase by the stimulus process
   int send_idle_pct;
   int stall_pct;
   // long hold-off handshake between the stimulus and the receiver process
   int holds_asked;
   int holds_done;

   // Directed script: either a register write or a request. Rows with
   // 'typed' set carry a hand-worked expectation; all others use the predictor.
   typedef struct packed {
      bit        is_cfg;
      bit [4:0]  cfg_value;
      bit [31:0] id;
      bit [3:0]  hint;
      bit        typed;
      bit [3:0]  unit;
      bit        hit;
   } script_row_type;

   script_row_type script [SCRIPT_LEN] = '{
      // after reset: 16 units, all empty with stamp 0
      '{1'b0, 5'd0,  32'h0000_0000, 4'd3,  1'b1, 4'd3, 1'b1},  // zero id hits an empty unit
      '{1'b0, 5'd0,  32'hFFFF_FFFF, 4'd0,  1'b1, 4'd1, 1'b0},  // hint 0 misses
      '{1'b0, 5'd0,  32'hFFFF_FFFF, 4'd1,  1'b1, 4'd1, 1'b1},
      '{1'b0, 5'd0,  32'h0000_0001, 4'd15, 1'b1, 4'd2, 1'b0},  // tie: lowest index wins
      '{1'b0, 5'd0,  32'h0000_0001, 4'd2,  1'b1, 4'd2, 1'b1},
      '{1'b0, 5'd0,  32'h8000_0001, 4'd8,  1'b0, 4'd0, 1'b0},
      '{1'b0, 5'd0,  32'h5555_5555, 4'd4,  1'b0, 4'd0, 1'b0},
      '{1'b0, 5'd0,  32'hAAAA_AAAA, 4'd10, 1'b0, 4'd0, 1'b0},
      '{1'b0, 5'd0,  32'h8000_0001, 4'd4,  1'b0, 4'd0, 1'b0},
      // two units: unit 1 is the only target
      '{1'b1, 5'd2,  32'h0,         4'd0,  1'b0, 4'd0, 1'b0},
      '{1'b0, 5'd0,  32'h0000_0007, 4'd1,  1'b1, 4'd1, 1'b0},
      '{1'b0, 5'd0,  32'h0000_0007, 4'd1,  1'b1, 4'd1, 1'b1},
      '{1'b0, 5'd0,  32'h0000_0007, 4'd2,  1'b1, 4'd1, 1'b0},  // hint beyond count
      // count below range clamps up to two
      '{1'b1, 5'd0,  32'h0,         4'd0,  1'b0, 4'd0, 1'b0},
      '{1'b0, 5'd0,  32'h0000_0009, 4'd1,  1'b1, 4'd1, 1'b0},
      '{1'b0, 5'd0,  32'h0000_0009, 4'd1,  1'b1, 4'd1, 1'b1},
      // count above range clamps down to sixteen
      '{1'b1, 5'd31, 32'h0,         4'd0,  1'b0, 4'd0, 1'b0},
      '{1'b0, 5'd0,  32'h0000_0009, 4'd15, 1'b0, 4'd0, 1'b0},
      '{1'b0, 5'd0,  32'hFFFF_FFFF, 4'd14, 1'b0, 4'd0, 1'b0},
      '{1'b0, 5'd0,  32'h0000_0000, 4'd0,  1'b0, 4'd0, 1'b0},  // zero id gets stored
      '{1'b1, 5'd1,  32'h0,         4'd0,  1'b0, 4'd0, 1'b0},
      '{1'b0, 5'd0,  32'h0000_0005, 4'd1,  1'b1, 4'd1, 1'b0},
      '{1'b0, 5'd0,  32'h0000_0005, 4'd0,  1'b1, 4'd1, 1'b0},
      '{1'b1, 5'd16, 32'h0,         4'd0,  1'b0, 4'd0, 1'b0}
   };

   // unit counts for the random phases, out-of-range values included
   bit [4:0] phase_units [PHASE_COUNT] = '{
      5'd16, 5'd2, 5'd31, 5'd0, 5'd5, 5'd1, 5'd17, 5'd9, 5'd16, 5'd12
   };

   // effective unit count: register clamped to 2..UNIT_COUNT
   function automatic int unsigned live_units();
      if (active_cfg > UNIT_COUNT) return UNIT_COUNT;
      if (active_cfg < 2) return 2;
      return 32'(active_cfg);
   endfunction

   // Advance the shadow table by one request and return the binding it gets.
   function automatic lbua_rsp_type bind_resource(input lbua_req_type r);
      int unsigned n;
      logic [UNIT_W-1:0] oldest;
      lbua_rsp_type res;
      n = live_units();
      use_count = use_count + 1;
      if (r.hint_unit >= 1 && r.hint_unit < n && unit_owner[r.hint_unit] == r.resource_id) begin
         unit_stamp[r.hint_unit] = use_count;
         res.assigned_unit = r.hint_unit;
         res.was_hit = 1'b1;
         return res;
      end
      oldest = UNIT_W'(1);
      for (int i = 2; i < n; i++) begin
         if (unit_stamp[i] < unit_stamp[oldest]) oldest = UNIT_W'(i);
      end
      unit_owner[oldest] = r.resource_id;
      unit_stamp[oldest] = use_count;
      res.assigned_unit = oldest;
      res.was_hit = 1'b0;
      return res;
   endfunction

   // Random request. Nearly half follow the caller's own record (id and the unit it
   // was bound to), so hits are frequent; the rest are stale hints, tiny ids,
   // all-ones ids and fully random ones.
   function automatic lbua_req_type pick_request();
      int unsigned n;
      int unsigned roll;
      int unsigned u;
      lbua_req_type r;
      n = live_units();
      roll = $urandom_range(0, 99);
      r.hint_unit = UNIT_W'($urandom_range(0, UNIT_COUNT - 1));
      if (roll < 45) begin
         u = $urandom_range(1, n - 1);
         r.resource_id = unit_owner[u];
         r.hint_unit = UNIT_W'(u);
      end else if (roll < 60) begin
         r.resource_id = unit_owner[$urandom_range(0, UNIT_COUNT - 1)];
      end else if (roll < 70) begin
         r.resource_id = ID_W'($urandom_range(0, 3));
      end else if (roll < 75) begin
         r.resource_id = '1;
      end else begin
         r.resource_id = $urandom;
      end
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Clock and reset
   // ---------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Request driver: drive on the falling edge, hold until accepted.
   // ---------------------------------------------------------------------
   task automatic drive_request(input lbua_req_type r);
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // predict, queue the expectation, then send
   task automatic issue_request(input lbua_req_type r);
      pending_bindings.push_back(bind_resource(r));
      drive_request(r);
   endtask

   // drop valid, wait until every expected response is back, then let the
   // block settle
   task automatic wait_drained(input int settle);
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_bindings.size() != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   // APB write of active_units, then a read back to confirm it stuck.
   task automatic write_active_units(input logic [CFG_W-1:0] value);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= ACTIVE_UNITS_ADDR;
      pwdata  <= 32'(value);
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      @(negedge clock);
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      if (prdata[CFG_W-1:0] !== value) begin
         $error("active_units: expected %0d, got %0d", value, prdata[CFG_W-1:0]);
         errors++;
      end
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      active_cfg = value;
   endtask

   // ---------------------------------------------------------------------
   // Response side: random stall, plus long hold-offs on demand.
   // ---------------------------------------------------------------------
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (holds_asked != holds_done) begin
            // keep stalling for a long stretch so the block backs up
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
            holds_done++;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < stall_pct);
         end
      end
   end

   // Response checker: in-order compare against the oldest expectation.
   always @(posedge clock) begin
      lbua_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_bindings.size() == 0) begin
            $error("response with nothing expected: unit %0d hit %0d",
                   rsp_data.assigned_unit, rsp_data.was_hit);
            errors++;
         end else begin
            want = pending_bindings.pop_front();
            if (rsp_data.assigned_unit !== want.assigned_unit) begin
               $error("assigned_unit: expected %0d, got %0d",
                      want.assigned_unit, rsp_data.assigned_unit);
               errors++;
            end
            if (rsp_data.was_hit !== want.was_hit) begin
               $error("was_hit: expected %0d, got %0d", want.was_hit, rsp_data.was_hit);
               errors++;
            end
         end
      end
   end

   // Watchdog: too long without any request or response moving ends the run.
   int quiet_cycles;
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------
   initial begin
      lbua_req_type r;
      lbua_rsp_type want;

      // every input known from time zero
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_data      = '0;
      psel          = 1'b0;
      penable       = 1'b0;
      pwrite        = 1'b0;
      paddr         = '0;
      pwdata        = '0;
      errors        = 0;
      send_idle_pct = 0;
      stall_pct     = 0;
      holds_asked   = 0;
      holds_done    = 0;
      for (int i = 0; i < UNIT_COUNT; i++) begin
         unit_owner[i] = '0;
         unit_stamp[i] = '0;
      end
      use_count  = '0;
      active_cfg = ACTIVE_UNITS_RESET;

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed script, no idling
      for (int s = 0; s < SCRIPT_LEN; s++) begin
         if (script[s].is_cfg) begin
            wait_drained(SETTLE_CYCLES);
            write_active_units(script[s].cfg_value);
         end else begin
            r.resource_id = script[s].id;
            r.hint_unit   = script[s].hint;
            want = bind_resource(r);   // keeps the shadow table in step
            if (script[s].typed) begin
               want.assigned_unit = script[s].unit;
               want.was_hit       = script[s].hit;
            end
            pending_bindings.push_back(want);
            drive_request(r);
         end
      end

      // random phases; the idle pattern rotates with the phase number
      for (int p = 0; p < PHASE_COUNT; p++) begin
         wait_drained(SETTLE_CYCLES);
         write_active_units(phase_units[p]);
         case (p % 4)
            0: begin
               send_idle_pct = 0;
               stall_pct     = 0;
            end
            1: begin
               send_idle_pct = 55;
               stall_pct     = 0;
            end
            2: begin
               send_idle_pct = 0;
               stall_pct     = 55;
            end
            default: begin
               send_idle_pct = 14;
               stall_pct     = 14;
            end
         endcase
         for (int k = 0; k < PHASE_REQUESTS; k++) begin
            // long receiver hold while requests keep coming
            if (p == 4 && k == 10) holds_asked++;
            // sender goes quiet until the block has answered everything
            if (p == 2 && k == 65) wait_drained(0);
            r = pick_request();
            issue_request(r);
         end
      end

      @(negedge clock);
      req_valid <= 1'b0;
      wait_drained(SETTLE_CYCLES);

      if (errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
